/* hw/rtl/wdt_pkg.sv */
// shared types and constants for the watchdog timer with key lock
package wdt_pkg;

    // action codes carried by a request transaction
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // register byte offsets
    localparam logic [7:0] OFF_CTRL   = 8'd0;
    localparam logic [7:0] OFF_LOAD   = 8'd4;
    localparam logic [7:0] OFF_COUNT  = 8'd8;
    localparam logic [7:0] OFF_STATUS = 8'd12;
    localparam logic [7:0] OFF_KEY    = 8'd16;

    // access checks
    localparam logic [7:0] ALIGN_MASK = 8'h03;
    localparam logic [3:0] GOOD_SIZE  = 4'd4;

    // control register bits
    localparam int CTL_EN    = 0;
    localparam int CTL_INTEN = 1;
    localparam int CTL_RSTEN = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  byte_offset;
        logic [3:0]  access_size;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic        access_error;
    } rsp_t;

    // internal flags reported by the register core
    typedef struct packed {
        logic irq;
        logic locked;
        logic running;
        logic timeout;
    } wdt_status_t;

endpackage

/* hw/rtl/wdt_req_if.sv */
// request channel: bus read, bus write or timer tick
interface wdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  byte_offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;

    modport source (output valid, action, byte_offset, access_size, write_data,
                    input ready);
    modport sink   (input valid, action, byte_offset, access_size, write_data,
                    output ready);
endinterface

/* hw/rtl/wdt_rsp_if.sv */
// response channel: read data, request line and error flag
interface wdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_level;
    logic        access_error;

    modport source (output valid, read_data, irq_level, access_error, input ready);
    modport sink   (input valid, read_data, irq_level, access_error, output ready);
endinterface

/* hw/rtl/watchdog_timer_key_lock.sv */
// watchdog timer with feed key and lock key, top level
//
// Usage: every request transaction on req is a bus read, a bus write or one
// timer tick; each one yields exactly one response transaction on rsp, in
// order. Registers: ctrl at 0, load at 4, count at 8 (read only), status at
// 12, key at 16 (write only). Only 4-byte aligned accesses are legal.
// The response carries read data, the sticky request line after this
// transaction and an access error flag.
//
// Pipeline: an accepted request enters the input register; its result then
// goes to the result register, which drives rsp.valid (input register, then
// result register). Throughput: one transaction per cycle while rsp does not
// stall; the counter and register state are updated once per transaction.
// When rsp stalls, the result register holds and the input register still
// takes one more transaction; req.ready then drops until rsp drains.
// Reset (rst_n low, asynchronous) clears both pipeline stages, stops the
// counter, clears ctrl, timeout, lock and the request line, and sets load
// and count to LOAD_RESET.
module watchdog_timer_key_lock #(
    parameter logic [31:0] LOAD_RESET = 32'd65535,
    parameter logic [31:0] FEED_KEY   = 32'd1515870810,
    parameter logic [31:0] LOCK_KEY   = 32'd449635665
) (
    input logic      clk,
    input logic      rst_n,
    wdt_req_if.sink  req,
    wdt_rsp_if.source rsp
);
    import wdt_pkg::*;

    logic        in_valid_reg;
    req_t        in_item_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_item_reg;
    logic        rsp_load;
    logic        step_en;
    rsp_t        step_result;
    wdt_status_t status;

    // handshake: result register frees on drain, input register moves forward
    assign rsp_load  = !rsp_valid_reg || rsp.ready;
    assign step_en   = in_valid_reg && rsp_load;
    assign req.ready = !in_valid_reg || rsp_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg.action      <= req.action;
            in_item_reg.byte_offset <= req.byte_offset;
            in_item_reg.access_size <= req.access_size;
            in_item_reg.write_data  <= req.write_data;
        end
    end

    // register state and transaction logic
    wdt_core #(
        .LOAD_RESET (LOAD_RESET),
        .FEED_KEY   (FEED_KEY),
        .LOCK_KEY   (LOCK_KEY)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_item_reg),
        .result  (step_result),
        .status  (status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            rsp_item_reg <= step_result;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_data    = rsp_item_reg.read_data;
    assign rsp.irq_level    = rsp_item_reg.irq_level;
    assign rsp.access_error = rsp_item_reg.access_error;

    // request line is sticky until reset
    a_irq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.irq |=> status.irq)
        else $error("request line dropped without reset");

    // lock holds until reset
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.locked |=> status.locked)
        else $error("lock released without reset");

    // a timeout always stops the counter
    a_timeout_stops: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status.timeout) |-> !status.running)
        else $error("counter still running after timeout");

    // every processed transaction shows up in the result register
    a_step_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> rsp_valid_reg)
        else $error("processed transaction lost before result register");

endmodule

/* hw/rtl/wdt_core.sv */
// watchdog register file, counter and per-transaction update logic
module wdt_core #(
    parameter logic [31:0] LOAD_RESET = 32'd65535,
    parameter logic [31:0] FEED_KEY   = 32'd1515870810,
    parameter logic [31:0] LOCK_KEY   = 32'd449635665
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  wdt_pkg::req_t        item,
    output wdt_pkg::rsp_t        result,
    output wdt_pkg::wdt_status_t status
);
    import wdt_pkg::*;

    logic [2:0]  ctrl_reg,    ctrl_next;
    logic [31:0] reload_reg,  reload_next;
    logic [31:0] count_reg,   count_next;
    logic        timeout_reg, timeout_next;
    logic        lock_reg,    lock_next;
    logic        running_reg, running_next;
    logic        irq_reg,     irq_next;
    logic [31:0] rd;
    logic        err;
    logic        bad_access;

    assign bad_access = (item.access_size != GOOD_SIZE) ||
                        ((item.byte_offset & ALIGN_MASK) != 8'd0);

    // next state and result for the transaction in the input register
    always_comb
    begin
        ctrl_next    = ctrl_reg;
        reload_next  = reload_reg;
        count_next   = count_reg;
        timeout_next = timeout_reg;
        lock_next    = lock_reg;
        running_next = running_reg;
        irq_next     = irq_reg;
        rd           = 32'd0;
        err          = 1'b0;
        case (action_t'(item.action))
            ACT_TICK:
            begin
                if (running_reg)
                begin
                    if (count_reg <= 32'd1)
                    begin
                        count_next   = 32'd0;
                        timeout_next = 1'b1;
                        running_next = 1'b0;
                        if (ctrl_reg[CTL_INTEN] || ctrl_reg[CTL_RSTEN])
                        begin
                            irq_next  = 1'b1;
                            ctrl_next = 3'd0;
                        end
                    end
                    else
                    begin
                        count_next = count_reg - 32'd1;
                    end
                end
            end
            ACT_READ:
            begin
                if (bad_access)
                begin
                    err = 1'b1;
                end
                else
                begin
                    case (item.byte_offset)
                        OFF_CTRL:   rd = {29'd0, ctrl_reg};
                        OFF_LOAD:   rd = reload_reg;
                        OFF_COUNT:  rd = count_reg;
                        OFF_STATUS: rd = {31'd0, timeout_reg};
                        OFF_KEY:    rd = 32'd0;
                        default:    err = 1'b1;
                    endcase
                end
            end
            ACT_WRITE:
            begin
                if (bad_access)
                begin
                    err = 1'b1;
                end
                else
                begin
                    case (item.byte_offset)
                        OFF_CTRL:
                        begin
                            if (!lock_reg)
                            begin
                                ctrl_next = item.write_data[2:0];
                                if (item.write_data[CTL_EN])
                                begin
                                    count_next   = reload_reg;
                                    running_next = 1'b1;
                                end
                                else
                                begin
                                    running_next = 1'b0;
                                end
                            end
                        end
                        OFF_LOAD:
                        begin
                            if (!lock_reg)
                            begin
                                reload_next = item.write_data;
                            end
                        end
                        OFF_COUNT:
                        begin
                            err = 1'b1;
                        end
                        OFF_STATUS:
                        begin
                            if (item.write_data[0])
                            begin
                                timeout_next = 1'b0;
                            end
                        end
                        OFF_KEY:
                        begin
                            if (item.write_data == FEED_KEY)
                            begin
                                if (ctrl_reg[CTL_EN])
                                begin
                                    count_next   = reload_reg;
                                    running_next = 1'b1;
                                    timeout_next = 1'b0;
                                end
                            end
                            else if (item.write_data == LOCK_KEY)
                            begin
                                lock_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            err = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                rd  = 32'd0;
                err = 1'b0;
            end
        endcase
    end

    assign result.read_data    = rd;
    assign result.irq_level    = irq_next;
    assign result.access_error = err;

    assign status.irq     = irq_reg;
    assign status.locked  = lock_reg;
    assign status.running = running_reg;
    assign status.timeout = timeout_reg;

    // state update, one transaction per cycle when step_en is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= 3'd0;
            reload_reg  <= LOAD_RESET;
            count_reg   <= LOAD_RESET;
            timeout_reg <= 1'b0;
            lock_reg    <= 1'b0;
            running_reg <= 1'b0;
            irq_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            ctrl_reg    <= ctrl_next;
            reload_reg  <= reload_next;
            count_reg   <= count_next;
            timeout_reg <= timeout_next;
            lock_reg    <= lock_next;
            running_reg <= running_next;
            irq_reg     <= irq_next;
        end
    end

endmodule
